### src/cps3d_pkg.sv
// ----------------------------------------------------------------------------
// cps3d_pkg: shared types and constants
// Fixed point widths, divider cell payload and configuration register layout
// for the closest point on segment block.
// ----------------------------------------------------------------------------
package cps3d_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int FRAC_W  = 16;
	localparam int QUO_W   = 33;
	localparam int CELLS   = QUO_W;
	localparam int REM_W   = MAG_W + QUO_W + 1;
	localparam int TC_W    = 17;
	localparam int SCL_W   = DIFF_W + TC_W + 1;

	localparam logic signed [COORD_W-1:0] T_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] T_MIN    = 32'sh8000_0000;
	localparam logic [QUO_W-1:0]          Q_POSLIM = 33'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0]          Q_NEGLIM = 33'h0_8000_0000;
	localparam logic [TC_W-1:0]           ONE_Q16  = 17'h1_0000;
	localparam logic signed [SCL_W-1:0]   HALF_LSB = 51'sd32768;

	typedef enum logic [2:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_GOAL_X  = 3'd3,
		REG_GOAL_Y  = 3'd4,
		REG_GOAL_Z  = 3'd5
	} reg_idx_t;

	typedef logic [2:0][COORD_W-1:0] coord3_t;

	typedef struct packed {
		coord3_t start;
		coord3_t goal;
	} seg_cfg_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] dsh;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             sat;
		logic             deg;
	} div_t;

	typedef struct packed {
		coord3_t                    near;
		logic signed [COORD_W-1:0]  t_unclamped;
		logic [TC_W-1:0]            t_clamped;
		logic [TC_W-1:0]            rest_scale;
	} res_t;

	function automatic logic signed [DIFF_W-1:0] coord_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		coord_diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction

endpackage

### src/cps3d_point_if.sv
// ----------------------------------------------------------------------------
// cps3d_point_if: query point channel
// Valid/ready channel carrying one query point per item.
// ----------------------------------------------------------------------------
interface cps3d_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

### src/cps3d_near_if.sv
// ----------------------------------------------------------------------------
// cps3d_near_if: closest point result channel
// Valid/ready channel carrying one result item per query.
// ----------------------------------------------------------------------------
interface cps3d_near_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] near_x;
	logic signed [31:0] near_y;
	logic signed [31:0] near_z;
	logic signed [31:0] t_unclamped;
	logic [16:0]        t_clamped;
	logic [16:0]        rest_scale;

	modport source (output valid, near_x, near_y, near_z, t_unclamped, t_clamped,
		rest_scale, input ready);
	modport sink (input valid, near_x, near_y, near_z, t_unclamped, t_clamped,
		rest_scale, output ready);
endinterface

### src/closest_point_on_segment_3d_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment_3d_top: closest point on a 3D segment
// Projects each query point onto the configured segment in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment start and goal (indices 0..5) on the cfg_* port while
//   no item is in flight. Query points enter on the point channel, results
//   leave on the near channel, one result item per query item, in order.
//   Each item passes five set-up stages, 33 divider cells (one quotient
//   bit each) and three scaling stages including the output register.
//   Throughput: one item per cycle while the receiver does not stall;
//   every stage and cell advances together.
//   When the receiver stalls with a result held, the whole chain holds and
//   point.ready falls; it rises again as soon as the result is taken.
//   Reset clears the segment registers to zero and drops all items in
//   flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module closest_point_on_segment_3d_top import cps3d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	cps3d_point_if.sink  point,
	cps3d_near_if.source near
);

	seg_cfg_t cfg_q;
	logic     en;
	logic     res_valid;
	res_t     res;
	coord3_t  pt;
	logic     chain_v [CELLS+1];
	div_t     chain_d [CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X: cfg_q.start[0] <= cfg_data;
				REG_START_Y: cfg_q.start[1] <= cfg_data;
				REG_START_Z: cfg_q.start[2] <= cfg_data;
				REG_GOAL_X:  cfg_q.goal[0]  <= cfg_data;
				REG_GOAL_Y:  cfg_q.goal[1]  <= cfg_data;
				REG_GOAL_Z:  cfg_q.goal[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en          = !res_valid || near.ready;
	assign point.ready = en;
	assign pt          = {point.point_z, point.point_y, point.point_x};

	cps3d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (point.valid),
		.pt        (pt),
		.cfg       (cfg_q),
		.out_valid (chain_v[0]),
		.out_data  (chain_d[0])
	);

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		cps3d_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	cps3d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chain_v[CELLS]),
		.in_data   (chain_d[CELLS]),
		.cfg       (cfg_q),
		.out_valid (res_valid),
		.out_data  (res)
	);

	assign near.valid       = res_valid;
	assign near.near_x      = res.near[0];
	assign near.near_y      = res.near[1];
	assign near.near_z      = res.near[2];
	assign near.t_unclamped = res.t_unclamped;
	assign near.t_clamped   = res.t_clamped;
	assign near.rest_scale  = res.rest_scale;

	a_scale_sum: assert property (@(posedge clk) disable iff (!arst_n)
		near.valid |-> (near.t_clamped + near.rest_scale) == {1'b0, ONE_Q16})
		else $error("t_clamped and rest_scale do not add to one");

	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		near.valid |-> near.t_clamped <= ONE_Q16)
		else $error("t_clamped above one");

	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(near.valid && cfg_q.start == cfg_q.goal) |-> near.t_unclamped == '0)
		else $error("degenerate segment gave nonzero t");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(near.valid && !near.ready) |-> !point.ready)
		else $error("query accepted while result stalled");

endmodule

### src/cps3d_front.sv
// ----------------------------------------------------------------------------
// cps3d_front: dot products and divider set-up
// Five stages: differences, products, sums, magnitude, dividend and
// saturation check. Feeds the first divider cell.
// ----------------------------------------------------------------------------
module cps3d_front import cps3d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  coord3_t  pt,
	input  seg_cfg_t cfg,
	output logic     out_valid,
	output div_t     out_data
);

	logic signed [DIFF_W-1:0] d [3];
	logic signed [DIFF_W-1:0] v_s1 [3];
	logic signed [PROD_W-1:0] pvd_s2 [3];
	logic signed [PROD_W-1:0] pdd_s2 [3];
	logic signed [SUM_W-1:0]  num_s3;
	logic signed [SUM_W-1:0]  den_s3;
	logic                     neg_s4;
	logic [MAG_W-1:0]         mag_s4;
	logic [MAG_W-1:0]         den_s4;
	logic [REM_W-1:0]         dividend;
	logic [4:0]               vld_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k] = coord_diff(cfg.goal[k], cfg.start[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				v_s1[k]   <= coord_diff(pt[k], cfg.start[k]);
				pvd_s2[k] <= v_s1[k] * d[k];
				pdd_s2[k] <= d[k] * d[k];
			end
			num_s3 <= SUM_W'(pvd_s2[0]) + SUM_W'(pvd_s2[1]) + SUM_W'(pvd_s2[2]);
			den_s3 <= SUM_W'(pdd_s2[0]) + SUM_W'(pdd_s2[1]) + SUM_W'(pdd_s2[2]);
			neg_s4 <= num_s3[SUM_W-1];
			mag_s4 <= num_s3[SUM_W-1] ? MAG_W'(-num_s3) : num_s3[MAG_W-1:0];
			den_s4 <= den_s3[MAG_W-1:0];
			out_data.rem <= dividend;
			out_data.dsh <= REM_W'({den_s4, 33'b0});
			out_data.quo <= '0;
			out_data.neg <= neg_s4;
			out_data.sat <= dividend >= REM_W'({den_s4, 34'b0});
			out_data.deg <= den_s4 == '0;
		end
	end

	assign dividend  = REM_W'({mag_s4, 17'b0}) + REM_W'(den_s4);
	assign out_valid = vld_q[4];

endmodule

### src/cps3d_div_cell.sv
// ----------------------------------------------------------------------------
// cps3d_div_cell: one restoring division step
// Trial subtract of the shifted divisor, one quotient bit, hand on.
// ----------------------------------------------------------------------------
module cps3d_div_cell import cps3d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  div_t in_data,
	output logic out_valid,
	output div_t out_data
);

	logic ge;

	assign ge = in_data.rem >= in_data.dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.rem <= ge ? in_data.rem - in_data.dsh : in_data.rem;
			out_data.dsh <= in_data.dsh >> 1;
			out_data.quo <= {in_data.quo[QUO_W-2:0], ge};
			out_data.neg <= in_data.neg;
			out_data.sat <= in_data.sat;
			out_data.deg <= in_data.deg;
		end
	end

endmodule

### src/cps3d_back.sv
// ----------------------------------------------------------------------------
// cps3d_back: saturate, clamp and scale
// Forms t from the quotient, clamps it, scales the segment and holds the
// result item in the output register.
// ----------------------------------------------------------------------------
module cps3d_back import cps3d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_t     in_data,
	input  seg_cfg_t cfg,
	output logic     out_valid,
	output res_t     out_data
);

	logic signed [COORD_W-1:0] t;
	logic [TC_W-1:0]           tc;
	logic signed [COORD_W-1:0] t_f1;
	logic [TC_W-1:0]           tc_f1;
	logic signed [COORD_W-1:0] t_f2;
	logic [TC_W-1:0]           tc_f2;
	logic signed [DIFF_W-1:0]  d [3];
	logic signed [SCL_W-1:0]   prod_f2 [3];
	logic signed [SCL_W-1:0]   rnd [3];
	logic [2:0]                vld_q;

	always_comb begin
		if (in_data.deg) begin
			t = '0;
		end else if (in_data.sat) begin
			t = in_data.neg ? T_MIN : T_MAX;
		end else if (!in_data.neg) begin
			t = (in_data.quo > Q_POSLIM) ? T_MAX : $signed(in_data.quo[COORD_W-1:0]);
		end else begin
			t = (in_data.quo > Q_NEGLIM) ? T_MIN : $signed(COORD_W'(~in_data.quo + 1'b1));
		end
		if (t[COORD_W-1]) begin
			tc = '0;
		end else if (t > $signed({15'b0, ONE_Q16})) begin
			tc = ONE_Q16;
		end else begin
			tc = t[TC_W-1:0];
		end
		for (int k = 0; k < 3; k++) begin
			d[k]   = coord_diff(cfg.goal[k], cfg.start[k]);
			rnd[k] = prod_f2[k] + HALF_LSB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_f1  <= t;
			tc_f1 <= tc;
			t_f2  <= t_f1;
			tc_f2 <= tc_f1;
			for (int k = 0; k < 3; k++) begin
				prod_f2[k] <= d[k] * $signed({1'b0, tc_f1});
				out_data.near[k] <= cfg.start[k] + COORD_W'(rnd[k] >>> FRAC_W);
			end
			out_data.t_unclamped <= t_f2;
			out_data.t_clamped   <= tc_f2;
			out_data.rest_scale  <= ONE_Q16 - tc_f2;
		end
	end

	assign out_valid = vld_q[2];

endmodule
